>>> sv/rbht_pkg.sv
// Package for the random-byte health test core: constants, status codes,
// register indexes and the histogram write request struct.
// No dependencies.
`default_nettype none

package rbht_pkg;

  // Aligned proportion-test window
  localparam int WINDOW_SIZE = 512;
  localparam int WIN_W       = $clog2(WINDOW_SIZE);
  localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW_SIZE - 1);

  // Field and counter widths
  localparam int BYTE_W  = 8;
  localparam int HIST_W  = 10;
  localparam int RUN_W   = 6;
  localparam int DIST_W  = 9;
  localparam int LEN_W   = 32;
  localparam int SMIN_W  = 9;
  localparam int HIST_DEPTH = 1 << BYTE_W;

  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
  localparam logic [HIST_W-1:0] HIST_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  // Register reset values
  localparam logic [RUN_W-1:0]  REP_CUT_RST  = RUN_W'(6);
  localparam logic [HIST_W-1:0] PROP_CUT_RST = HIST_W'(16);
  localparam logic [SMIN_W-1:0] SMIN_RST     = SMIN_W'(16);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REP_CUTOFF  = 2'd0,
    CFG_PROP_CUTOFF = 2'd1,
    CFG_SHORT_MIN   = 2'd2
  } cfg_index_t;

  // Health status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_SAME  = 3'd2,
    ST_REP   = 3'd3,
    ST_PROP  = 3'd4,
    ST_NOSRC = 3'd5
  } status_t;

  // Histogram update issued by the processing stage
  typedef struct packed {
    logic              en;         // update the entry this cycle
    logic              win_start;  // first byte of a window: all counts read as zero
    logic [BYTE_W-1:0] addr;       // byte value being counted
  } hist_wr_t;

endpackage

`default_nettype wire

>>> sv/rbht_hist.sv
// Per-window value histogram: 256 x 10 synchronous RAM with per-entry valid
// flops for the window clear and one-deep write forwarding.
// Depends on rbht_pkg.
`default_nettype none

module rbht_hist (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [rbht_pkg::BYTE_W-1:0] rd_addr,
  input  wire rbht_pkg::hist_wr_t        wr,
  output logic [rbht_pkg::HIST_W-1:0]    cnt_new
);
  import rbht_pkg::*;

  logic [HIST_W-1:0]     mem [HIST_DEPTH];
  logic [HIST_W-1:0]     rd_data;
  logic [HIST_DEPTH-1:0] hist_valid;
  logic                  fwd_sel;
  logic [HIST_W-1:0]     fwd_data;
  logic [HIST_W-1:0]     cnt_old;

  // Read port: issued when a byte transfer is accepted
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port: bump the entry of the byte in the processing stage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= cnt_new;
    end
  end

  // Forward a write that lands on the same edge as the read of the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (rd_en) begin
      fwd_sel <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= cnt_new;
    end
  end

  // Valid flops: clear all at a window start, mark the entry written
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (wr.en) begin
      hist_valid <= (wr.win_start ? '0 : hist_valid) | (HIST_DEPTH'(1) << wr.addr);
    end
  end

  // Old count, then saturating increment
  always_comb begin
    if (wr.win_start) begin
      cnt_old = '0;
    end else if (fwd_sel) begin
      cnt_old = fwd_data;
    end else if (hist_valid[wr.addr]) begin
      cnt_old = rd_data;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == HIST_MAX) ? cnt_old : cnt_old + HIST_W'(1);
  end

endmodule

`default_nettype wire

>>> sv/rng_byte_health_test_core.sv
// Top level of the random-byte health test: stream ports, configuration
// registers, processing stage and result register.
// Depends on rbht_pkg and rbht_hist.
`default_nettype none

// Health test for buffers of random-source bytes, one byte per transfer, with
// s_tlast on the last byte and s_tuser marking an empty buffer. One status
// transfer leaves per buffer: ok, all zero, all same, repetition run,
// proportion (windowed counts of 512 bytes, or too few distinct values in a
// short buffer) or no source, with the saturating byte count. The block takes
// one byte per cycle unless a buffer end meets a held result; a result is
// loaded as the last byte leaves the processing stage. The rate is set by the
// histogram RAM read-modify-write: read on accept, write as the byte leaves,
// a same-entry write by the previous byte forwarded. Configuration must be
// written only while idle, not enforced; no clearing pass is needed after reset.
module rng_byte_health_test_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input byte stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] sample_byte
  input  wire logic                          s_tlast,   // final_byte
  input  wire logic                          s_tuser,   // [0] empty_buffer
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [39:0]                        m_tdata,   // [2:0] health_status,
                                                        // [34:3] checked_length
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import rbht_pkg::*;

  // Configuration registers
  logic [RUN_W-1:0]  rep_cutoff;
  logic [HIST_W-1:0] prop_cutoff;
  logic [SMIN_W-1:0] short_min;

  // Processing stage
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_empty;
  logic              s1_advance;
  logic              s1_produce;
  logic              restart;

  // Buffer state
  logic [LEN_W-1:0]  byte_count;
  logic              zeros_only;
  logic              same_only;
  logic [BYTE_W-1:0] first_value;
  logic [BYTE_W-1:0] previous_value;
  logic [RUN_W-1:0]  run_count;
  logic              repeat_failed;
  logic              window_failed;
  logic              window_pending_hit;
  logic [WIN_W-1:0]  window_position;
  logic [DIST_W-1:0] distinct_count;

  logic [LEN_W-1:0]  byte_count_next;
  logic              zeros_only_next;
  logic              same_only_next;
  logic [BYTE_W-1:0] first_value_next;
  logic [RUN_W-1:0]  run_count_next;
  logic              repeat_failed_next;
  logic              window_failed_next;
  logic              window_pending_hit_next;
  logic [WIN_W-1:0]  window_position_next;
  logic [DIST_W-1:0] distinct_count_next;
  logic              hit;
  logic              first_byte;
  status_t           status_next;

  // Histogram interface
  hist_wr_t          hist_wr;
  logic [HIST_W-1:0] hist_cnt;

  // Result register
  logic              out_valid;
  status_t           out_status;
  logic [LEN_W-1:0]  out_length;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_cutoff  <= REP_CUT_RST;
      prop_cutoff <= PROP_CUT_RST;
      short_min   <= SMIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REP_CUTOFF:  rep_cutoff  <= cfg_data[RUN_W-1:0];
        CFG_PROP_CUTOFF: prop_cutoff <= cfg_data[HIST_W-1:0];
        CFG_SHORT_MIN:   short_min   <= cfg_data[SMIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall the stage only when it has a result and the result register is held
  assign s1_produce = s1_valid && (s1_last || s1_empty);
  assign s1_advance = s1_valid && !(s1_produce && out_valid && !m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign restart    = s1_advance && (s1_last || s1_empty);

  // Capture the accepted transfer into the processing stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte  <= s_tdata;
      s1_last  <= s_tlast;
      s1_empty <= s_tuser;
    end
  end

  // Histogram RAM with forwarding
  assign hist_wr.en        = s1_advance && !s1_empty;
  assign hist_wr.win_start = (window_position == '0);
  assign hist_wr.addr      = s1_byte;

  rbht_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_tready && s_tvalid),
    .rd_addr (s_tdata),
    .wr      (hist_wr),
    .cnt_new (hist_cnt)
  );

  // Update the buffer state for the byte in the processing stage
  always_comb begin
    first_byte       = (byte_count == '0);
    first_value_next = first_byte ? s1_byte : first_value;
    if (first_byte || (s1_byte != previous_value)) begin
      run_count_next = RUN_W'(1);
    end else if (run_count != RUN_MAX) begin
      run_count_next = run_count + RUN_W'(1);
    end else begin
      run_count_next = run_count;
    end
    repeat_failed_next = repeat_failed || (!first_byte && (run_count_next >= rep_cutoff));
    same_only_next     = same_only && (first_byte || (s1_byte == first_value));
    zeros_only_next    = zeros_only && (s1_byte == '0);

    hit = window_pending_hit || (hist_cnt >= prop_cutoff);
    if (window_position == WIN_LAST) begin
      window_failed_next      = window_failed || hit;
      window_pending_hit_next = 1'b0;
      window_position_next    = '0;
    end else begin
      window_failed_next      = window_failed;
      window_pending_hit_next = hit;
      window_position_next    = window_position + WIN_W'(1);
    end

    // A short buffer lies inside its first window, so a count of one marks a
    // value not seen before in the buffer; past the first window the distinct
    // count is never judged
    distinct_count_next = (hist_cnt == HIST_W'(1)) ? distinct_count + DIST_W'(1)
                                                   : distinct_count;
    byte_count_next = (byte_count == LEN_MAX) ? byte_count : byte_count + LEN_W'(1);

    // Judge the buffer as it stands after this byte
    if (zeros_only_next) begin
      status_next = ST_ZERO;
    end else if (same_only_next && (byte_count_next > LEN_W'(1))) begin
      status_next = ST_SAME;
    end else if (repeat_failed_next) begin
      status_next = ST_REP;
    end else if (window_failed_next) begin
      status_next = ST_PROP;
    end else if ((byte_count_next >= LEN_W'(short_min)) &&
                 (byte_count_next < LEN_W'(WINDOW_SIZE)) &&
                 (LEN_W'(distinct_count_next) < (byte_count_next >> 2))) begin
      status_next = ST_PROP;
    end else begin
      status_next = ST_OK;
    end
  end

  // Buffer state registers: restart at a buffer end, advance on a byte
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_count         <= '0;
      zeros_only         <= 1'b1;
      same_only          <= 1'b1;
      first_value        <= '0;
      previous_value     <= '0;
      run_count          <= '0;
      repeat_failed      <= 1'b0;
      window_failed      <= 1'b0;
      window_pending_hit <= 1'b0;
      window_position    <= '0;
      distinct_count     <= '0;
    end else if (s1_advance && !s1_empty) begin
      byte_count         <= byte_count_next;
      zeros_only         <= zeros_only_next;
      same_only          <= same_only_next;
      first_value        <= first_value_next;
      previous_value     <= s1_byte;
      run_count          <= run_count_next;
      repeat_failed      <= repeat_failed_next;
      window_failed      <= window_failed_next;
      window_pending_hit <= window_pending_hit_next;
      window_position    <= window_position_next;
      distinct_count     <= distinct_count_next;
    end
  end

  // Result register: load at a buffer end, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_produce) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_produce) begin
      if (s1_empty) begin
        out_status <= ST_NOSRC;
        out_length <= '0;
      end else begin
        out_status <= status_next;
        out_length <= byte_count_next;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_length, out_status};

endmodule

`default_nettype wire

>>> dv/tb_rng_byte_health_test_core.sv
// Self-checking testbench for rng_byte_health_test_core: streams byte buffers,
// predicts each buffer's health status and length, and checks every result.
// Depends on rbht_pkg and the RTL of the core.
`default_nettype none

module tb_rng_byte_health_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rbht_pkg::*;

  localparam int SETTLE      = 8;     // cycles past the last result before idle
  localparam int STALL_LIMIT = 5000;  // cycles without any transfer
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int PRINT_MAX   = 40;

  typedef struct {
    logic [7:0] sample;
    bit         last;
    bit         empty;
  } byte_xfer_t;

  typedef struct {
    status_t     status;
    logic [31:0] length;
  } verdict_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum {SRC_NOISE, SRC_PALETTE, SRC_RUNS, SRC_ZEROS, SRC_CONSTANT, SRC_ABORTED}
    pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_REP_CUTOFF;
  logic [15:0] cfg_data  = '0;

  rng_byte_health_test_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and checking state
  byte_xfer_t pending[$];
  byte_xfer_t on_wire;
  verdict_t   verdicts_due[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic       hold_arm  = 1'b0;
  logic       hold_used = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;
  int         bytes_taken = 0;
  int         results_seen = 0;
  int         tally [6];

  // Health model: register copies
  logic [5:0]  rep_limit;
  logic [9:0]  prop_limit;
  logic [8:0]  short_floor;

  // Health model: per-buffer state
  logic [31:0]      len_cnt;
  bit               only_zeros;
  bit               all_equal;
  logic [7:0]       head_byte;
  logic [7:0]       last_byte;
  logic [5:0]       run_len;
  bit               run_hit;
  bit               win_hit;
  bit               win_armed;
  logic [WIN_W-1:0] win_pos;
  logic [9:0]       counts [256];
  bit               seen [256];
  logic [8:0]       n_distinct;

  initial forever #5 clk = ~clk;

  function automatic void restart_buffer();
    len_cnt    = '0;
    only_zeros = 1'b1;
    all_equal  = 1'b1;
    head_byte  = '0;
    last_byte  = '0;
    run_len    = '0;
    run_hit    = 1'b0;
    win_hit    = 1'b0;
    win_armed  = 1'b0;
    win_pos    = '0;
    counts     = '{default: '0};
    seen       = '{default: 1'b0};
    n_distinct = '0;
  endfunction

  // Fold one accepted byte transfer into the model; queue a verdict at buffer end
  function automatic void health_step(input byte_xfer_t x);
    verdict_t   v;
    logic [7:0] b;
    b = x.sample;
    if (x.empty) begin
      restart_buffer();
      v.status = ST_NOSRC;
      v.length = '0;
      verdicts_due.push_back(v);
      tally[ST_NOSRC]++;
      return;
    end
    // repetition run and coarse checks
    if (len_cnt == 0) begin
      head_byte = b;
      run_len   = 6'd1;
    end else begin
      if (b == last_byte) begin
        if (run_len != RUN_MAX) run_len++;
      end else begin
        run_len = 6'd1;
      end
      if (run_len >= rep_limit) run_hit = 1'b1;
      if (b != head_byte) all_equal = 1'b0;
    end
    if (b != 8'h00) only_zeros = 1'b0;
    last_byte = b;
    // windowed proportion counts, cleared at each window start
    if (win_pos == 0) counts = '{default: '0};
    if (counts[b] != HIST_MAX) counts[b]++;
    if (counts[b] >= prop_limit) win_armed = 1'b1;
    if (win_pos == WIN_LAST) begin
      if (win_armed) win_hit = 1'b1;
      win_armed = 1'b0;
      win_pos   = '0;
    end else begin
      win_pos++;
    end
    if (!seen[b]) begin
      seen[b] = 1'b1;
      n_distinct++;
    end
    if (len_cnt != LEN_MAX) len_cnt++;
    if (!x.last) return;
    // pick the first failure in priority order
    if (only_zeros)                     v.status = ST_ZERO;
    else if (all_equal && len_cnt > 1)  v.status = ST_SAME;
    else if (run_hit)                   v.status = ST_REP;
    else if (win_hit)                   v.status = ST_PROP;
    else if (len_cnt >= short_floor && len_cnt < WINDOW_SIZE && n_distinct < len_cnt / 4)
      v.status = ST_PROP;
    else                                v.status = ST_OK;
    v.length = len_cnt;
    verdicts_due.push_back(v);
    tally[v.status]++;
    restart_buffer();
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("ERROR %0t ns: %s", $time, what);
  endtask

  // Decide whether one side idles this cycle
  function automatic bit take_break(input bit sender_side);
    bit on;
    on = (idle_mode == IDLE_BOTH) || (idle_mode == (sender_side ? IDLE_SEND : IDLE_RECV));
    if (!on) return 1'b0;
    return $urandom_range(0, 99) < ((idle_mode == IDLE_BOTH) ? 32 : 81);
  endfunction

  function automatic byte_xfer_t xfer(input logic [7:0] s, input bit l, input bit e);
    byte_xfer_t x;
    x.sample = s;
    x.last   = l;
    x.empty  = e;
    return x;
  endfunction

  // Queue one buffer of the given pattern; return the number of transfers queued
  function automatic int queue_buffer(input int len, input pattern_t pat, input int spread);
    logic [7:0] palette [64];
    logic [7:0] fill;
    int         left_in_run;
    logic [7:0] b;
    fill = 8'($urandom_range(1, 255));
    left_in_run = 0;
    for (int i = 0; i < 64; i++) palette[i] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (pat)
        SRC_ZEROS:    b = 8'h00;
        SRC_CONSTANT: b = fill;
        SRC_PALETTE:  b = palette[$urandom_range(0, spread - 1)];
        SRC_RUNS: begin
          if (left_in_run == 0) begin
            fill = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
            left_in_run = $urandom_range(1, spread);
          end
          b = fill;
          left_in_run--;
        end
        default:      b = 8'($urandom);
      endcase
      pending.push_back(xfer(b, (i == len - 1) && (pat != SRC_ABORTED), 1'b0));
    end
    if (pat == SRC_ABORTED) begin
      // drop the partial buffer with an empty marker carrying junk fields
      pending.push_back(xfer(8'($urandom), 1'($urandom), 1'b1));
      return len + 1;
    end
    return len;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      CFG_REP_CUTOFF:  rep_limit   = val[5:0];
      CFG_PROP_CUTOFF: prop_limit  = val[9:0];
      CFG_SHORT_MIN:   short_floor = val[8:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued transfer is in and every verdict is out, then settle;
  // look between edges so the driver's update of the edge is already visible
  task automatic drain();
    while (pending.size() != 0 || s_tvalid || verdicts_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input bit program_regs, input logic [15:0] rep,
                           input logic [15:0] prop, input logic [15:0] smin,
                           input idle_mode_t mode, input bit hold_off, input int budget,
                           input int long_len, input int long_pal);
    int       added;
    int       long_at;
    bit       long_done;
    int       len;
    int       pick;
    int       spread;
    pattern_t pat;
    drain();
    if (program_regs) begin
      write_reg(CFG_REP_CUTOFF, rep);
      write_reg(CFG_PROP_CUTOFF, prop);
      write_reg(CFG_SHORT_MIN, smin);
    end
    @(negedge clk);
    idle_mode <= mode;
    if (hold_off) hold_arm <= 1'b1;
    added     = 0;
    long_at   = $urandom_range(0, budget);
    long_done = (long_len == 0);
    while (added < budget || !long_done) begin
      if (!long_done && added >= long_at) begin
        added += queue_buffer(long_len, (long_pal == 0) ? SRC_NOISE : SRC_PALETTE, long_pal);
        long_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25)      pat = SRC_NOISE;
        else if (pick < 50) pat = SRC_PALETTE;
        else if (pick < 70) pat = SRC_RUNS;
        else if (pick < 78) pat = SRC_ZEROS;
        else if (pick < 86) pat = SRC_CONSTANT;
        else                pat = SRC_ABORTED;
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(1, 24);
        else if (pick < 95) len = $urandom_range(25, 120);
        else                len = $urandom_range(121, 200);
        if (pat == SRC_ABORTED) len = $urandom_range(0, 30);
        if (pat == SRC_RUNS)
          spread = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(2, 12);
        else
          spread = $urandom_range(1, 8);
        added += queue_buffer(len, pat, spread);
      end
    end
  endtask

  // Drive byte transfers from the pending queue; hold valid until accepted
  always @(posedge clk) begin : byte_driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        health_step(on_wire);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && !take_break(1'b1)) begin
          on_wire = pending.pop_front();
          s_tdata  <= on_wire.sample;
          s_tlast  <= on_wire.last;
          s_tuser  <= on_wire.empty;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count down the one long receiver hold-off
  always @(posedge clk) begin : hold_counter
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Compare each result transfer against the oldest predicted verdict
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d length %0d",
                                    m_tdata[2:0], m_tdata[34:3]));
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[2:0] !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                      results_seen, m_tdata[2:0], want.status.name()));
          if (m_tdata[34:3] !== want.length)
            report_mismatch($sformatf("result %0d: length %0d, expected %0d",
                                      results_seen, m_tdata[34:3], want.length));
        end
      end
      m_tready <= (hold_left == 0) && !take_break(1'b0);
    end
  end

  // End the run when no transfer of any kind happens for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR %0t ns: no transfer for %0d cycles, %0d verdicts outstanding",
               $time, quiet_cycles, verdicts_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : main_sequence
    rep_limit   = REP_CUT_RST;
    prop_limit  = PROP_CUT_RST;
    short_floor = SMIN_RST;
    restart_buffer();
    tally = '{default: 0};

    // Directed buffers under the reset settings
    pending.push_back(xfer(8'hFF, 1'b1, 1'b1));        // empty marker wins over last
    void'(queue_buffer(1, SRC_ZEROS, 1));              // single zero byte
    pending.push_back(xfer(8'hFF, 1'b1, 1'b0));        // single byte passes
    pending.push_back(xfer(8'hA5, 1'b0, 1'b0));        // two identical bytes
    pending.push_back(xfer(8'hA5, 1'b1, 1'b0));
    void'(queue_buffer(3, SRC_ZEROS, 1));              // all zero
    pending.push_back(xfer(8'h12, 1'b0, 1'b0));        // partial buffer, then dropped
    pending.push_back(xfer(8'h34, 1'b0, 1'b0));
    pending.push_back(xfer(8'h00, 1'b1, 1'b1));
    pending.push_back(xfer(8'h01, 1'b0, 1'b0));        // run reaching the cutoff
    repeat (5) pending.push_back(xfer(8'h07, 1'b0, 1'b0));
    pending.push_back(xfer(8'h07, 1'b1, 1'b0));
    pending.push_back(xfer(8'h80, 1'b0, 1'b0));        // mixed bytes, trailing zeros
    pending.push_back(xfer(8'h00, 1'b0, 1'b0));
    pending.push_back(xfer(8'h00, 1'b1, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings, one full window plus a trailing part from a small alphabet
    run_phase(1'b0, 0, 0, 0, IDLE_NONE, 1'b0, 90,
              $urandom_range(540, 600), $urandom_range(12, 40));
    // Low extremes
    run_phase(1'b1, 2, 2, 1, IDLE_SEND, 1'b0, 90, 0, 0);
    // High extremes
    run_phase(1'b1, 63, 512, 511, IDLE_RECV, 1'b0, 90, 0, 0);
    // Zero cutoffs and zero floor
    run_phase(1'b1, 0, 0, 0, IDLE_BOTH, 1'b0, 90, 0, 0);
    // Cutoff of one on runs, widest count cutoff, long receiver hold-off
    run_phase(1'b1, 1, 1023, 16'($urandom_range(1, 511)), IDLE_NONE, 1'b1, 90, 0, 0);
    // Count cutoff of one, random run cutoff and floor
    run_phase(1'b1, 16'($urandom_range(8, 63)), 1, 16'($urandom_range(1, 511)), IDLE_SEND,
              1'b0, 90, 0, 0);
    // Mid count cutoff with both sides idling
    run_phase(1'b1, 16'($urandom_range(8, 63)), 10, 16'($urandom_range(1, 511)), IDLE_BOTH,
              1'b0, 90, 0, 0);

    drain();
    $display("Run covered %0d byte transfers and %0d results over seven register settings.",
             bytes_taken, results_seen);
    $display("Statuses: ok %0d, all zero %0d, all same %0d, repetition %0d, proportion %0d, %s%0d",
             tally[ST_OK], tally[ST_ZERO], tally[ST_SAME], tally[ST_REP], tally[ST_PROP],
             "no source ", tally[ST_NOSRC]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> rng_byte_health_test_core.f
sv/rbht_pkg.sv
sv/rbht_hist.sv
sv/rng_byte_health_test_core.sv
dv/tb_rng_byte_health_test_core.sv
